### src/fhi_pkg.sv
// Shared types and constants for the frame header inserter.
package fhi_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FLEN_W     = 16;
  localparam int unsigned PLEN_W     = 3;
  localparam int unsigned SIGNS_W    = 4;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned SW_W       = 4;
  localparam int unsigned PAD_W      = 4;
  localparam int unsigned PART_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_SIGNS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING_LENGTH  = 3'd4;

  // Register reset values.
  localparam logic [PLEN_W-1:0]  RST_PREAMBLE_LENGTH = 3'd1;
  localparam logic [SIGNS_W-1:0] RST_PREAMBLE_SIGNS  = 4'd0;
  localparam logic [AMP_W-1:0]   RST_AMPLITUDE       = 15'd16384;
  localparam logic [SW_W-1:0]    RST_SYMBOL_WIDTH    = 4'd8;
  localparam logic [PAD_W-1:0]   RST_PADDING_LENGTH  = 4'd0;

  // floor(0.8 * w) for w up to 64 equals (w * 820) >> 10.
  localparam logic [16:0] FS_MUL   = 17'd820;
  localparam int unsigned FS_SHIFT = 10;

  // Tag of each emitted sample.
  typedef enum logic [PART_W-1:0] {
    PART_DATA = 3'd0,
    PART_SYNC = 3'd1,
    PART_FREQ = 3'd2,
    PART_LEN  = 3'd3,
    PART_PAD  = 3'd4
  } part_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic  load;       // capture the accepted item
    logic  emit;       // load the output register
    part_e part;       // which sample to build
    logic  last;       // last result of the item
    logic  sym_next;   // step to the next preamble symbol
    logic  len_shift;  // step to the next length bit
  } cmd_t;

endpackage

### src/fhi_cfg.sv
// Configuration registers with range limiting and derived run counts.
module fhi_cfg #(
  parameter int MAX_PREAMBLE     = 4,
  parameter int MAX_SYMBOL_WIDTH = 8,
  parameter int MAX_PADDING      = 8,
  parameter int CW               = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fhi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fhi_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [CW-1:0]                     plen_o,
  output logic [CW-1:0]                     sw_o,
  output logic [CW-1:0]                     fs_o,
  output logic [CW-1:0]                     pad_o,
  output logic [MAX_PREAMBLE-1:0]           signs_o,
  output logic                              last_neg_o,
  output logic [fhi_pkg::AMP_W-1:0]         amp_o
);

  logic [fhi_pkg::PLEN_W-1:0]  plen_q;
  logic [fhi_pkg::SIGNS_W-1:0] signs_q;
  logic [fhi_pkg::AMP_W-1:0]   amp_q;
  logic [fhi_pkg::SW_W-1:0]    sw_q;
  logic [fhi_pkg::PAD_W-1:0]   pad_q;
  logic [16:0]                 fs_prod;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= fhi_pkg::RST_PREAMBLE_LENGTH;
      signs_q <= fhi_pkg::RST_PREAMBLE_SIGNS;
      amp_q   <= fhi_pkg::RST_AMPLITUDE;
      sw_q    <= fhi_pkg::RST_SYMBOL_WIDTH;
      pad_q   <= fhi_pkg::RST_PADDING_LENGTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fhi_pkg::REG_PREAMBLE_LENGTH: plen_q  <= cfg_data_i[fhi_pkg::PLEN_W-1:0];
        fhi_pkg::REG_PREAMBLE_SIGNS:  signs_q <= cfg_data_i[fhi_pkg::SIGNS_W-1:0];
        fhi_pkg::REG_AMPLITUDE:       amp_q   <= cfg_data_i[fhi_pkg::AMP_W-1:0];
        fhi_pkg::REG_SYMBOL_WIDTH:    sw_q    <= cfg_data_i[fhi_pkg::SW_W-1:0];
        fhi_pkg::REG_PADDING_LENGTH:  pad_q   <= cfg_data_i[fhi_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit the counts to the ranges the hardware supports.
  always_comb begin
    if (plen_q == '0) begin
      plen_o = CW'(1);
    end else if (32'(plen_q) > 32'(MAX_PREAMBLE)) begin
      plen_o = CW'(MAX_PREAMBLE);
    end else begin
      plen_o = CW'(plen_q);
    end

    if (sw_q == '0) begin
      sw_o = CW'(1);
    end else if (32'(sw_q) > 32'(MAX_SYMBOL_WIDTH)) begin
      sw_o = CW'(MAX_SYMBOL_WIDTH);
    end else begin
      sw_o = CW'(sw_q);
    end

    if (32'(pad_q) > 32'(MAX_PADDING)) begin
      pad_o = CW'(MAX_PADDING);
    end else begin
      pad_o = CW'(pad_q);
    end
  end

  // Frequency-sync run length by reciprocal multiplication.
  assign fs_prod = 17'(sw_o) * fhi_pkg::FS_MUL;
  assign fs_o    = CW'(fs_prod >> fhi_pkg::FS_SHIFT);

  // Sign bits widened to the preamble depth; the last symbol's sign is picked out.
  always_comb begin
    signs_o    = '0;
    last_neg_o = 1'b0;
    for (int i = 0; i < MAX_PREAMBLE; i++) begin
      if (i < int'(fhi_pkg::SIGNS_W)) begin
        signs_o[i] = signs_q[i[1:0]];
      end
      if (CW'(i + 1) == plen_o) begin
        last_neg_o = signs_o[i];
      end
    end
  end

  assign amp_o = amp_q;

endmodule

### src/fhi_ctrl.sv
// Sequencer state machine that walks through the header, data and padding runs.
module fhi_ctrl #(
  parameter int LENGTH_BITS = 16,
  parameter int CW          = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          start_i,
  input  logic          end_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic [CW-1:0] plen_i,
  input  logic [CW-1:0] sw_i,
  input  logic [CW-1:0] fs_i,
  input  logic [CW-1:0] pad_i,
  output fhi_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SYNC = 3'd1;
  localparam logic [2:0] ST_FREQ = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_PAD  = 3'd5;

  localparam logic [CW-1:0] LEN_LAST = CW'(LENGTH_BITS - 1);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] sym_q, sym_d;
  logic [CW-1:0] rep_q, rep_d;
  logic          end_q, end_d;
  logic          out_valid_q, out_valid_d;
  logic          adv;
  logic          fin;
  logic          in_ready;

  // Next state, counters and datapath commands.
  always_comb begin
    adv     = !out_valid_q || !out_stall_i;
    fin     = 1'b0;
    cmd_o   = '0;
    state_d = state_q;
    sym_d   = sym_q;
    rep_d   = rep_q;
    end_d   = end_q;

    case (state_q)
      ST_IDLE: ;
      ST_SYNC: begin
        if (adv) begin
          cmd_o.emit = 1'b1;
          cmd_o.part = fhi_pkg::PART_SYNC;
          if (rep_q == sw_i - 1'b1) begin
            rep_d = '0;
            if (sym_q == plen_i - 1'b1) begin
              state_d = (fs_i != '0) ? ST_FREQ : ST_LEN;
            end else begin
              sym_d          = sym_q + 1'b1;
              cmd_o.sym_next = 1'b1;
            end
          end else begin
            rep_d = rep_q + 1'b1;
          end
        end
      end
      ST_FREQ: begin
        if (adv) begin
          cmd_o.emit = 1'b1;
          cmd_o.part = fhi_pkg::PART_FREQ;
          if (rep_q == fs_i - 1'b1) begin
            rep_d   = '0;
            state_d = ST_LEN;
          end else begin
            rep_d = rep_q + 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (adv) begin
          cmd_o.emit      = 1'b1;
          cmd_o.part      = fhi_pkg::PART_LEN;
          cmd_o.len_shift = 1'b1;
          if (rep_q == LEN_LAST) begin
            rep_d   = '0;
            state_d = ST_DATA;
          end else begin
            rep_d = rep_q + 1'b1;
          end
        end
      end
      ST_DATA: begin
        if (adv) begin
          cmd_o.emit = 1'b1;
          cmd_o.part = fhi_pkg::PART_DATA;
          if (end_q && (pad_i != '0)) begin
            rep_d   = '0;
            state_d = ST_PAD;
          end else begin
            cmd_o.last = 1'b1;
            fin        = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (adv) begin
          cmd_o.emit = 1'b1;
          cmd_o.part = fhi_pkg::PART_PAD;
          if (rep_q == pad_i - 1'b1) begin
            cmd_o.last = 1'b1;
            fin        = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            rep_d = rep_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A new item enters when idle or as the last result of the current one leaves.
    in_ready = (state_q == ST_IDLE) || fin;
    if (in_valid_i && in_ready) begin
      cmd_o.load = 1'b1;
      end_d      = end_i;
      sym_d      = '0;
      rep_d      = '0;
      state_d    = start_i ? ST_SYNC : ST_DATA;
    end

    // Output register valid flag.
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sym_q       <= '0;
      rep_q       <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sym_q       <= sym_d;
      rep_q       <= rep_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;

endmodule

### src/fhi_dp.sv
// Datapath: item capture, sign and length shifters, sample builder and output register.
module fhi_dp #(
  parameter int MAX_PREAMBLE = 4,
  parameter int LENGTH_BITS  = 16
) (
  input  logic                                   clk_i,
  input  fhi_pkg::cmd_t                          cmd_i,
  input  logic signed [fhi_pkg::SAMPLE_W-1:0]    in_re_i,
  input  logic signed [fhi_pkg::SAMPLE_W-1:0]    in_im_i,
  input  logic                                   length_valid_i,
  input  logic [fhi_pkg::FLEN_W-1:0]             frame_length_i,
  input  logic [MAX_PREAMBLE-1:0]                signs_i,
  input  logic                                   last_neg_i,
  input  logic [fhi_pkg::AMP_W-1:0]              amp_i,
  output logic signed [fhi_pkg::SAMPLE_W-1:0]    out_re_o,
  output logic signed [fhi_pkg::SAMPLE_W-1:0]    out_im_o,
  output logic [fhi_pkg::PART_W-1:0]             part_o,
  output logic                                   run_last_o
);

  logic signed [fhi_pkg::SAMPLE_W-1:0] re_q, im_q;
  logic                                lv_q;
  logic [LENGTH_BITS-1:0]              len_q;
  logic [MAX_PREAMBLE-1:0]             sgn_q;
  logic [LENGTH_BITS-1:0]              len_ext;

  logic [fhi_pkg::SAMPLE_W-1:0]        amp_pos, amp_neg;
  logic                                neg;
  logic [fhi_pkg::SAMPLE_W-1:0]        sym_val;
  logic signed [fhi_pkg::SAMPLE_W-1:0] re_d, im_d;

  logic signed [fhi_pkg::SAMPLE_W-1:0] out_re_q, out_im_q;
  logic [fhi_pkg::PART_W-1:0]          part_q;
  logic                                last_q;

  // Frame length fitted to the length field; higher bits are dropped.
  always_comb begin
    len_ext = '0;
    for (int i = 0; i < LENGTH_BITS; i++) begin
      if (i < int'(fhi_pkg::FLEN_W)) begin
        len_ext[i] = frame_length_i[i[3:0]];
      end
    end
  end

  // Item capture and the shifters that step through symbols and length bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      re_q  <= in_re_i;
      im_q  <= in_im_i;
      lv_q  <= length_valid_i;
      len_q <= len_ext;
      sgn_q <= signs_i;
    end else begin
      if (cmd_i.sym_next) begin
        sgn_q <= sgn_q >> 1;
      end
      if (cmd_i.len_shift) begin
        len_q <= len_q << 1;
      end
    end
  end

  // Build the sample for the current part.
  always_comb begin
    amp_pos = {1'b0, amp_i};
    amp_neg = (~amp_pos) + 16'd1;
    case (cmd_i.part)
      fhi_pkg::PART_SYNC: neg = sgn_q[0];
      fhi_pkg::PART_FREQ: neg = last_neg_i;
      fhi_pkg::PART_LEN:  neg = last_neg_i ^ !len_q[LENGTH_BITS-1];
      default:            neg = 1'b0;
    endcase
    sym_val = neg ? amp_neg : amp_pos;

    case (cmd_i.part)
      fhi_pkg::PART_DATA: begin
        re_d = re_q;
        im_d = im_q;
      end
      fhi_pkg::PART_SYNC, fhi_pkg::PART_FREQ: begin
        re_d = sym_val;
        im_d = '0;
      end
      fhi_pkg::PART_LEN: begin
        re_d = lv_q ? sym_val : '0;
        im_d = '0;
      end
      default: begin
        re_d = '0;
        im_d = '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_re_q <= re_d;
      out_im_q <= im_d;
      part_q   <= cmd_i.part;
      last_q   <= cmd_i.last;
    end
  end

  assign out_re_o   = out_re_q;
  assign out_im_o   = out_im_q;
  assign part_o     = part_q;
  assign run_last_o = last_q;

endmodule

### src/frame_header_inserter.sv
// Frame header inserter top level: configuration, sequencer and datapath.
//
// Each input item is one complex Q2.14 sample. An item with a start mark is
// preceded by a header: the sync word (each preamble symbol repeated
// symbol_width times), a frequency-sync run of floor(0.8*symbol_width) copies
// of the last symbol, and LENGTH_BITS length symbols sent most significant bit
// first. An item with an end mark is followed by padding_length zero samples.
// Every result carries a part tag, and run_last marks the last result of an
// item. The sequencer puts out one result per clock, unless the output stalls,
// through a single output register. An item has 1 result for a plain sample,
// plus preamble_length*symbol_width + floor(0.8*symbol_width) + LENGTH_BITS
// with a start mark, plus padding_length with an end mark. The next item is
// taken in the cycle the last result of the current one is registered, so plain
// samples flow at one per cycle unless the output stalls. The user must write
// configuration only while the block is idle; the block does not enforce this.
module frame_header_inserter #(
  parameter int MAX_PREAMBLE     = 4,
  parameter int MAX_SYMBOL_WIDTH = 8,
  parameter int MAX_PADDING      = 8,
  parameter int LENGTH_BITS      = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fhi_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fhi_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [fhi_pkg::SAMPLE_W-1:0]  in_re_i,
  input  logic signed [fhi_pkg::SAMPLE_W-1:0]  in_im_i,
  input  logic                                 start_mark_i,
  input  logic                                 end_mark_i,
  input  logic                                 length_valid_i,
  input  logic [fhi_pkg::FLEN_W-1:0]           frame_length_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [fhi_pkg::SAMPLE_W-1:0]  out_re_o,
  output logic signed [fhi_pkg::SAMPLE_W-1:0]  out_im_o,
  output logic [fhi_pkg::PART_W-1:0]           part_o,
  output logic                                 run_last_o
);

  // Counter width covers the longest run of any part.
  localparam int RUN_A   = (MAX_PREAMBLE > MAX_SYMBOL_WIDTH) ? MAX_PREAMBLE : MAX_SYMBOL_WIDTH;
  localparam int RUN_B   = (MAX_PADDING > LENGTH_BITS) ? MAX_PADDING : LENGTH_BITS;
  localparam int RUN_MAX = (RUN_A > RUN_B) ? RUN_A : RUN_B;
  localparam int CW      = $clog2(RUN_MAX + 1);

  logic [CW-1:0]           plen, sw, fs, pad;
  logic [MAX_PREAMBLE-1:0] signs;
  logic                    last_neg;
  logic [fhi_pkg::AMP_W-1:0] amp;
  fhi_pkg::cmd_t           cmd;

  fhi_cfg #(
    .MAX_PREAMBLE     (MAX_PREAMBLE),
    .MAX_SYMBOL_WIDTH (MAX_SYMBOL_WIDTH),
    .MAX_PADDING      (MAX_PADDING),
    .CW               (CW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .plen_o     (plen),
    .sw_o       (sw),
    .fs_o       (fs),
    .pad_o      (pad),
    .signs_o    (signs),
    .last_neg_o (last_neg),
    .amp_o      (amp)
  );

  fhi_ctrl #(
    .LENGTH_BITS (LENGTH_BITS),
    .CW          (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_i     (start_mark_i),
    .end_i       (end_mark_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .plen_i      (plen),
    .sw_i        (sw),
    .fs_i        (fs),
    .pad_i       (pad),
    .cmd_o       (cmd)
  );

  fhi_dp #(
    .MAX_PREAMBLE (MAX_PREAMBLE),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .in_re_i        (in_re_i),
    .in_im_i        (in_im_i),
    .length_valid_i (length_valid_i),
    .frame_length_i (frame_length_i),
    .signs_i        (signs),
    .last_neg_i     (last_neg),
    .amp_i          (amp),
    .out_re_o       (out_re_o),
    .out_im_o       (out_im_o),
    .part_o         (part_o),
    .run_last_o     (run_last_o)
  );

endmodule

### src/fhi_checker.sv
// Port-level checker for the frame header inserter, bound to the top level.
module fhi_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [fhi_pkg::SAMPLE_W-1:0]  out_re_o,
  input logic signed [fhi_pkg::SAMPLE_W-1:0]  out_im_o,
  input logic [fhi_pkg::PART_W-1:0]           part_o,
  input logic                                 run_last_o
);

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_re_o) && $stable(out_im_o) &&
                                   $stable(part_o) && $stable(run_last_o))
    else $error("stalled result changed");

  // Header and padding samples are real.
  a_real_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (part_o != fhi_pkg::PART_DATA) |-> out_im_o == '0)
    else $error("nonzero imaginary part outside data");

  // An item ends only on its data sample or a padding sample.
  a_last_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_last_o |->
      (part_o == fhi_pkg::PART_DATA) || (part_o == fhi_pkg::PART_PAD))
    else $error("run ended inside the header");

  // Length symbols are followed at once by another length symbol or the sample.
  a_len_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (part_o == fhi_pkg::PART_LEN) |=>
      out_valid_o && ((part_o == fhi_pkg::PART_LEN) || (part_o == fhi_pkg::PART_DATA)))
    else $error("gap or wrong part after a length symbol");

endmodule

bind frame_header_inserter fhi_checker u_fhi_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the frame header inserter: directed table, then random frames.
module tb;
  import fhi_pkg::*;

  // Instance sizes; the predictor saturates the registers to the same bounds.
  localparam int unsigned MAX_PREAMBLE     = 4;
  localparam int unsigned MAX_SYMBOL_WIDTH = 8;
  localparam int unsigned MAX_PADDING      = 8;
  localparam int unsigned LENGTH_BITS      = 16;

  localparam int unsigned CYCLE_LIMIT        = 1_000_000;
  localparam int unsigned DRAIN_LIMIT        = 50_000;
  localparam int unsigned SETTLE_CYCLES      = 4;
  localparam int unsigned MAX_REPORTS        = 10;
  localparam int unsigned PHASE_COUNT        = 4;
  localparam int unsigned SETTINGS_PER_PHASE = 3;
  localparam int unsigned ITEMS_PER_SETTING  = 35;
  localparam int unsigned N_DIRECTED         = 43;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_PADDING_LENGTH + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] re;
    logic [SAMPLE_W-1:0] im;
    logic                start_mark;
    logic                end_mark;
    logic                length_valid;
    logic [FLEN_W-1:0]   frame_length;
  } in_sample_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] re;
    logic [SAMPLE_W-1:0] im;
    part_e               part;
    logic                last;
  } out_sample_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    in_sample_t            smp;
    logic                  typed;
    logic [SAMPLE_W-1:0]   typed_re;
    logic [SAMPLE_W-1:0]   typed_im;
  } directed_row_t;

  localparam in_sample_t NO_SAMPLE = '0;

  // Directed stimulus. Rows marked typed carry their single data result by hand;
  // the rest are checked against the predictor.
  // kind, register, data, {re, im, start, end, length valid, length}, typed, re, im
  directed_row_t directed [N_DIRECTED] = '{
    // Reset settings: one plus symbol of width 8, no padding.
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h7fff, 16'h8000, 1'b0, 1'b0, 1'b0, 16'h0000},
      1'b1, 16'h7fff, 16'h8000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h8000, 16'h7fff, 1'b0, 1'b0, 1'b0, 16'h0000},
      1'b1, 16'h8000, 16'h7fff},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h0000, 16'hffff, 1'b0, 1'b1, 1'b0, 16'h0000},
      1'b1, 16'h0000, 16'hffff},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h4000, 16'h0000, 1'b1, 1'b0, 1'b1, 16'hffff},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'hc000, 16'h4000, 1'b1, 1'b0, 1'b0, 16'ha5a5},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 16'h0000},
      1'b0, 16'h0000, 16'h0000},
    // Longest preamble, full amplitude, narrowest symbols, most padding.
    '{ROW_REG, REG_PREAMBLE_LENGTH, 15'd4, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PREAMBLE_SIGNS, 15'ha, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_AMPLITUDE, 15'h7fff, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_SYMBOL_WIDTH, 15'd1, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PADDING_LENGTH, 15'd8, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h1234, 16'hedcb, 1'b1, 1'b0, 1'b1, 16'h8001},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'hffff, 16'hffff, 1'b0, 1'b1, 1'b0, 16'h0000},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h7fff, 16'h7fff, 1'b1, 1'b1, 1'b1, 16'h1234},
      1'b0, 16'h0000, 16'h0000},
    // Values below range saturate up, padding above range saturates down, zero amplitude.
    '{ROW_REG, REG_PREAMBLE_LENGTH, 15'd0, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_SYMBOL_WIDTH, 15'd0, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PADDING_LENGTH, 15'd15, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_AMPLITUDE, 15'd0, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PREAMBLE_SIGNS, 15'd1, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h8000, 16'h8000, 1'b1, 1'b1, 1'b1, 16'hffff},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h0001, 16'hfffe, 1'b0, 1'b0, 1'b1, 16'hffff},
      1'b1, 16'h0001, 16'hfffe},
    // Values above range saturate down; spare indexes change nothing.
    '{ROW_REG, REG_PREAMBLE_LENGTH, 15'd7, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_SYMBOL_WIDTH, 15'd15, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PREAMBLE_SIGNS, 15'hf, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_AMPLITUDE, 15'd1, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PADDING_LENGTH, 15'd9, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_SPARE_LO, 15'h7fff, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_SPARE_HI, 15'h7fff, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h2aaa, 16'hd555, 1'b1, 1'b1, 1'b1, 16'h5555},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h5555, 16'haaaa, 1'b1, 1'b0, 1'b1, 16'haaaa},
      1'b0, 16'h0000, 16'h0000},
    // Sign bit above the preamble length is set but must be ignored.
    '{ROW_REG, REG_PREAMBLE_LENGTH, 15'd3, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PREAMBLE_SIGNS, 15'ha, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_AMPLITUDE, 15'h4000, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_SYMBOL_WIDTH, 15'd5, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PADDING_LENGTH, 15'd1, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h0100, 16'hff00, 1'b1, 1'b1, 1'b1, 16'h00ff},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h4000, 16'hc000, 1'b0, 1'b1, 1'b0, 16'h0000},
      1'b0, 16'h0000, 16'h0000},
    // Negative last symbol, so the length symbols flip polarity.
    '{ROW_REG, REG_PREAMBLE_LENGTH, 15'd2, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_SYMBOL_WIDTH, 15'd2, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PADDING_LENGTH, 15'd0, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_REG, REG_PREAMBLE_SIGNS, 15'd3, NO_SAMPLE, 1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'h0f0f, 16'hf0f0, 1'b1, 1'b0, 1'b1, 16'hf0f0},
      1'b0, 16'h0000, 16'h0000},
    '{ROW_ITEM, REG_PREAMBLE_LENGTH, 15'd0, '{16'hffff, 16'h0000, 1'b1, 1'b1, 1'b0, 16'hffff},
      1'b0, 16'h0000, 16'h0000}
  };

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic signed [SAMPLE_W-1:0] in_re_i   = '0;
  logic signed [SAMPLE_W-1:0] in_im_i   = '0;
  logic                  start_mark_i   = 1'b0;
  logic                  end_mark_i     = 1'b0;
  logic                  length_valid_i = 1'b0;
  logic [FLEN_W-1:0]     frame_length_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_re_o;
  logic signed [SAMPLE_W-1:0] out_im_o;
  logic [PART_W-1:0]     part_o;
  logic                  run_last_o;

  // Hand-typed expectation that travels with a directed item.
  logic                typed_expect = 1'b0;
  logic [SAMPLE_W-1:0] typed_re     = '0;
  logic [SAMPLE_W-1:0] typed_im     = '0;

  // Shadow copy of the configuration registers.
  logic [PLEN_W-1:0]  cfg_plen  = RST_PREAMBLE_LENGTH;
  logic [SIGNS_W-1:0] cfg_signs = RST_PREAMBLE_SIGNS;
  logic [AMP_W-1:0]   cfg_amp   = RST_AMPLITUDE;
  logic [SW_W-1:0]    cfg_sw    = RST_SYMBOL_WIDTH;
  logic [PAD_W-1:0]   cfg_pad   = RST_PADDING_LENGTH;

  out_sample_t awaited_samples [$];

  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  int unsigned failures        = 0;
  int unsigned results_checked = 0;
  int unsigned items_taken     = 0;
  int unsigned reg_writes      = 0;
  int unsigned cycle_count     = 0;

  frame_header_inserter #(
    .MAX_PREAMBLE     (MAX_PREAMBLE),
    .MAX_SYMBOL_WIDTH (MAX_SYMBOL_WIDTH),
    .MAX_PADDING      (MAX_PADDING),
    .LENGTH_BITS      (LENGTH_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_re_i        (in_re_i),
    .in_im_i        (in_im_i),
    .start_mark_i   (start_mark_i),
    .end_mark_i     (end_mark_i),
    .length_valid_i (length_valid_i),
    .frame_length_i (frame_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_re_o       (out_re_o),
    .out_im_o       (out_im_o),
    .part_o         (part_o),
    .run_last_o     (run_last_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Header level for one preamble symbol: plus or minus the amplitude, as 16 bits.
  function automatic logic [SAMPLE_W-1:0] preamble_level(input logic negative);
    logic [SAMPLE_W-1:0] mag;
    mag = {1'b0, cfg_amp};
    return negative ? (~mag + 1'b1) : mag;
  endfunction

  function automatic void await_sample(input logic [SAMPLE_W-1:0] re,
                                       input logic [SAMPLE_W-1:0] im, input part_e part);
    out_sample_t s;
    s.re   = re;
    s.im   = im;
    s.part = part;
    s.last = 1'b0;
    awaited_samples.push_back(s);
  endfunction

  // Queue up every sample that one input item makes the block emit.
  function automatic void frame_samples_for(input in_sample_t smp);
    int unsigned plen;
    int unsigned width;
    int unsigned pad;
    int unsigned fs_run;
    logic last_neg;
    logic [SAMPLE_W-1:0] level;
    plen  = cfg_plen;
    width = cfg_sw;
    pad   = cfg_pad;
    if (plen < 1) plen = 1;
    if (plen > MAX_PREAMBLE) plen = MAX_PREAMBLE;
    if (width < 1) width = 1;
    if (width > MAX_SYMBOL_WIDTH) width = MAX_SYMBOL_WIDTH;
    if (pad > MAX_PADDING) pad = MAX_PADDING;

    if (smp.start_mark) begin
      last_neg = cfg_signs[plen-1];
      fs_run   = (4 * width) / 5;
      // Sync word, then the frequency-sync run of the last symbol.
      for (int sym = 0; sym < plen; sym++) begin
        level = preamble_level(cfg_signs[sym]);
        repeat (width) await_sample(level, '0, PART_SYNC);
      end
      repeat (fs_run) await_sample(preamble_level(last_neg), '0, PART_FREQ);
      // Length symbols, most significant bit first; a 1 keeps the last symbol's sign.
      for (int b = LENGTH_BITS - 1; b >= 0; b--) begin
        level = '0;
        if (smp.length_valid) begin
          level = preamble_level(smp.frame_length[b] ? last_neg : !last_neg);
        end
        await_sample(level, '0, PART_LEN);
      end
    end

    await_sample(smp.re, smp.im, PART_DATA);
    if (smp.end_mark) begin
      repeat (pad) await_sample('0, '0, PART_PAD);
    end
    awaited_samples[awaited_samples.size()-1].last = 1'b1;
  endfunction

  // Track register writes, check each emitted sample and predict each taken item.
  always @(posedge clk_i) begin
    in_sample_t  seen;
    out_sample_t want;
    if (!rst_ni) begin
      cfg_plen  = RST_PREAMBLE_LENGTH;
      cfg_signs = RST_PREAMBLE_SIGNS;
      cfg_amp   = RST_AMPLITUDE;
      cfg_sw    = RST_SYMBOL_WIDTH;
      cfg_pad   = RST_PADDING_LENGTH;
    end else begin
      if (cfg_we_i) begin
        reg_writes++;
        case (cfg_idx_i)
          REG_PREAMBLE_LENGTH: cfg_plen  = cfg_data_i[PLEN_W-1:0];
          REG_PREAMBLE_SIGNS:  cfg_signs = cfg_data_i[SIGNS_W-1:0];
          REG_AMPLITUDE:       cfg_amp   = cfg_data_i[AMP_W-1:0];
          REG_SYMBOL_WIDTH:    cfg_sw    = cfg_data_i[SW_W-1:0];
          REG_PADDING_LENGTH:  cfg_pad   = cfg_data_i[PAD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_o && !out_stall_i) begin
        if (awaited_samples.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("unexpected sample: re=%h im=%h part=%0d last=%b",
                     out_re_o, out_im_o, part_o, run_last_o);
          end
        end else begin
          want = awaited_samples.pop_front();
          results_checked++;
          if (out_re_o !== want.re || out_im_o !== want.im ||
              part_o !== want.part || run_last_o !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("mismatch at sample %0d: expected re=%h im=%h part=%0d last=%b",
                       results_checked, want.re, want.im, want.part, want.last);
              $display("                       got      re=%h im=%h part=%0d last=%b",
                       out_re_o, out_im_o, part_o, run_last_o);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        items_taken++;
        if (typed_expect) begin
          awaited_samples.push_back('{typed_re, typed_im, PART_DATA, 1'b1});
        end else begin
          seen.re           = in_re_i;
          seen.im           = in_im_i;
          seen.start_mark   = start_mark_i;
          seen.end_mark     = end_mark_i;
          seen.length_valid = length_valid_i;
          seen.frame_length = frame_length_i;
          frame_samples_for(seen);
        end
      end
    end
  end

  // Present one item after an optional random gap and hold it until it is taken.
  task automatic offer_item(input in_sample_t smp, input logic typed,
                            input logic [SAMPLE_W-1:0] t_re, input logic [SAMPLE_W-1:0] t_im);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_re_i        <= smp.re;
    in_im_i        <= smp.im;
    start_mark_i   <= smp.start_mark;
    end_mark_i     <= smp.end_mark;
    length_valid_i <= smp.length_valid;
    frame_length_i <= smp.frame_length;
    typed_expect   <= typed;
    typed_re       <= t_re;
    typed_im       <= t_im;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering items and let every awaited sample come out.
  task automatic wait_idle(input int unsigned bound);
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_samples.size() != 0 && waited < bound) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("timeout after %0d cycles, %0d samples still awaited",
             cycle_count, awaited_samples.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_sample_t smp;
    logic [AMP_W-1:0] amp;
    int unsigned frame_items;
    int unsigned frame_left;
    logic broken;
    frame_items = 0;
    frame_left  = 0;
    broken      = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, no idling.
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed[r].kind == ROW_REG) begin
        wait_idle(CYCLE_LIMIT);
        write_reg(directed[r].reg_idx, directed[r].reg_data);
      end else begin
        offer_item(directed[r].smp, directed[r].typed, directed[r].typed_re,
                   directed[r].typed_im);
      end
    end

    // Random frames under four idling patterns, with fresh settings now and then.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 77;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct     = 19;
        end
      endcase

      for (int st = 0; st < SETTINGS_PER_PHASE; st++) begin
        wait_idle(CYCLE_LIMIT);
        // Mostly legal settings, sometimes anything the register width allows.
        write_reg(REG_PREAMBLE_LENGTH, CFG_DATA_W'(($urandom_range(5) == 0) ?
                  $urandom_range(7) : $urandom_range(MAX_PREAMBLE, 1)));
        write_reg(REG_PREAMBLE_SIGNS, CFG_DATA_W'($urandom_range(15)));
        case ($urandom_range(5))
          0: amp = '0;
          1: amp = '1;
          default: amp = AMP_W'($urandom);
        endcase
        write_reg(REG_AMPLITUDE, CFG_DATA_W'(amp));
        write_reg(REG_SYMBOL_WIDTH, CFG_DATA_W'(($urandom_range(5) == 0) ?
                  $urandom_range(15) : $urandom_range(MAX_SYMBOL_WIDTH, 1)));
        write_reg(REG_PADDING_LENGTH, CFG_DATA_W'(($urandom_range(5) == 0) ?
                  $urandom_range(15) : $urandom_range(MAX_PADDING)));
        if ($urandom_range(3) == 0) begin
          write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(REG_SPARE_HI - REG_SPARE_LO)),
                    CFG_DATA_W'($urandom));
        end

        frame_left = 0;
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          // Well-formed frames with a start on the first item and an end on the last;
          // now and then a frame with random marks.
          if (frame_left == 0) begin
            frame_items = $urandom_range(6, 1);
            frame_left  = frame_items;
            broken      = ($urandom_range(7) == 0);
          end
          smp.start_mark = (frame_left == frame_items);
          smp.end_mark   = (frame_left == 1);
          if (broken) begin
            smp.start_mark = 1'($urandom_range(1));
            smp.end_mark   = 1'($urandom_range(1));
          end
          frame_left--;

          smp.re = ($urandom_range(9) == 0) ?
                   (($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN) : SAMPLE_W'($urandom);
          smp.im = ($urandom_range(9) == 0) ?
                   (($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN) : SAMPLE_W'($urandom);
          smp.length_valid = ($urandom_range(4) != 0);
          smp.frame_length = ($urandom_range(9) == 0) ?
                             {FLEN_W{1'($urandom_range(1))}} : FLEN_W'($urandom);
          offer_item(smp, 1'b0, '0, '0);
        end
      end
    end

    wait_idle(DRAIN_LIMIT);
    if (awaited_samples.size() != 0) begin
      $display("%0d samples never came out", awaited_samples.size());
      failures += awaited_samples.size();
    end

    $display("Sent %0d items (directed table plus random frames under four idling patterns),",
             items_taken);
    $display("checked %0d output samples, %0d register writes, %0d failures.",
             results_checked, reg_writes, failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
